FILE: hw/rtl/gss_pkg.sv
package gss_pkg;

    localparam int STEPS      = 12;
    localparam int CHANNELS   = 8;
    localparam int PHASE_BITS = 32;

    localparam int STEP_W  = $clog2(STEPS);
    localparam int COUNT_W = $clog2(STEPS + 1);
    localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed at the ports
    localparam int INC_W      = 32;
    localparam int REQ_W      = 4;
    localparam int TOG_CH_W   = 3;
    localparam int TOG_STEP_W = 4;
    localparam int GATES_W    = 8;
    localparam int CUR_STEP_W = 4;

    typedef logic [CHANNELS-1:0] gate_row_t;

    typedef struct packed {
        logic              running;
        logic              advanced;
        logic [STEP_W-1:0] step;
    } seq_status_t;

endpackage

FILE: hw/rtl/gss_timing.sv
module gss_timing (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         run_button,
    input  logic                         reset_level,
    input  logic                         ext_clock_connected,
    input  logic                         ext_clock_level,
    input  logic [gss_pkg::INC_W-1:0]    phase_increment,
    input  logic [gss_pkg::REQ_W-1:0]    step_count_request,
    output gss_pkg::seq_status_t         status_next
);
    import gss_pkg::*;

    logic                  run_reg, run_next;
    logic                  prev_run_reg, prev_clk_reg, prev_rst_reg;
    logic                  prev_clk_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [PHASE_BITS:0]   phase_sum;
    logic [COUNT_W-1:0]    count;
    logic [COUNT_W:0]      step_inc;
    logic                  advance;
    logic                  rst_edge;

    assign phase_sum = {1'b0, phase_reg} + {1'b0, PHASE_BITS'(phase_increment)};
    assign rst_edge  = reset_level && !prev_rst_reg;

    always_comb begin
        // clamp the active step count to 1..STEPS
        if (step_count_request == '0) begin
            count = COUNT_W'(1);
        end else if (int'(step_count_request) > STEPS) begin
            count = COUNT_W'(STEPS);
        end else begin
            count = COUNT_W'(step_count_request);
        end
    end

    assign step_inc = (COUNT_W + 1)'(step_reg) + (COUNT_W + 1)'(1);

    always_comb begin
        run_next      = run_reg ^ (run_button && !prev_run_reg);
        prev_clk_next = prev_clk_reg;
        phase_next    = phase_reg;
        advance       = 1'b0;
        step_next     = step_reg;

        if (run_next) begin
            if (ext_clock_connected) begin
                if (ext_clock_level && !prev_clk_reg) begin
                    phase_next = '0;
                    advance    = 1'b1;
                end
                prev_clk_next = ext_clock_level;
            end else begin
                phase_next = phase_sum[PHASE_BITS-1:0];
                advance    = phase_sum[PHASE_BITS];
            end
        end

        if (rst_edge) begin
            phase_next = '0;
            step_next  = '0;
            advance    = 1'b1;
        end else if (advance) begin
            if (step_inc >= {1'b0, count}) begin
                step_next = '0;
            end else begin
                step_next = step_inc[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b1;
            prev_run_reg <= 1'b0;
            prev_clk_reg <= 1'b0;
            prev_rst_reg <= 1'b0;
            phase_reg    <= '0;
            step_reg     <= '0;
        end else if (accept) begin
            run_reg      <= run_next;
            prev_run_reg <= run_button;
            prev_clk_reg <= prev_clk_next;
            prev_rst_reg <= reset_level;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
        end
    end

    assign status_next.running  = run_next;
    assign status_next.advanced = advance;
    assign status_next.step     = step_next;

endmodule

FILE: hw/rtl/gss_grid.sv
module gss_grid (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic                            toggle_valid,
    input  logic [gss_pkg::TOG_CH_W-1:0]    toggle_channel,
    input  logic [gss_pkg::TOG_STEP_W-1:0]  toggle_step,
    input  logic [gss_pkg::STEP_W-1:0]      read_step,
    output gss_pkg::gate_row_t              read_row
);
    import gss_pkg::*;

    gate_row_t grid_reg  [STEPS];
    gate_row_t grid_next [STEPS];
    logic      hit;

    assign hit = toggle_valid && (int'(toggle_step) < STEPS)
              && (int'(toggle_channel) < CHANNELS);

    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            grid_next[s] = grid_reg[s];
        end
        // flip one cell
        if (hit) begin
            grid_next[STEP_W'(toggle_step)] = grid_reg[STEP_W'(toggle_step)]
                ^ (gate_row_t'(1) << CHAN_W'(toggle_channel));
        end
    end

    // read sees this word's toggle
    assign read_row = grid_next[read_step];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STEPS; s++) begin
                grid_reg[s] <= '0;
            end
        end else if (accept) begin
            for (int s = 0; s < STEPS; s++) begin
                grid_reg[s] <= grid_next[s];
            end
        end
    end

endmodule

FILE: hw/rtl/gate_step_sequencer.sv
// Result: a word accepted at the input is valid at the output in the cycle after.
// Throughput: one word per cycle unless a pending result waits on m_ready; the
// state update and the result register are written together, and the input is
// taken while the result register is being drained.
// Reset (aresetn, synchronous, active low): grid cleared, step 0, phase 0,
// running, edge detectors low, no result pending.
module gate_step_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_run_button,
    input  logic                             s_reset_level,
    input  logic                             s_ext_clock_connected,
    input  logic                             s_ext_clock_level,
    input  logic [gss_pkg::INC_W-1:0]        s_phase_increment,
    input  logic [gss_pkg::REQ_W-1:0]        s_step_count_request,
    input  logic                             s_toggle_valid,
    input  logic [gss_pkg::TOG_CH_W-1:0]     s_toggle_channel,
    input  logic [gss_pkg::TOG_STEP_W-1:0]   s_toggle_step,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gss_pkg::GATES_W-1:0]      m_channel_gates,
    output logic [gss_pkg::CUR_STEP_W-1:0]   m_current_step,
    output logic                             m_running,
    output logic                             m_step_advanced
);
    import gss_pkg::*;

    logic                  accept;
    seq_status_t           status_next;
    gate_row_t             row;
    logic                  valid_reg;
    logic [GATES_W-1:0]    gates_reg;
    logic [CUR_STEP_W-1:0] step_reg;
    logic                  running_reg;
    logic                  advanced_reg;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    gss_timing u_timing (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .accept              (accept),
        .run_button          (s_run_button),
        .reset_level         (s_reset_level),
        .ext_clock_connected (s_ext_clock_connected),
        .ext_clock_level     (s_ext_clock_level),
        .phase_increment     (s_phase_increment),
        .step_count_request  (s_step_count_request),
        .status_next         (status_next)
    );

    gss_grid u_grid (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .toggle_valid   (s_toggle_valid),
        .toggle_channel (s_toggle_channel),
        .toggle_step    (s_toggle_step),
        .read_step      (status_next.step),
        .read_row       (row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gates_reg    <= GATES_W'(row);
            step_reg     <= CUR_STEP_W'(status_next.step);
            running_reg  <= status_next.running;
            advanced_reg <= status_next.advanced;
        end
    end

    assign m_valid         = valid_reg;
    assign m_channel_gates = gates_reg;
    assign m_current_step  = step_reg;
    assign m_running       = running_reg;
    assign m_step_advanced = advanced_reg;

endmodule
